// ----- sv/arcsine_polynomial_assert.svh -----
// Assertion macros shared by the arcsine polynomial block.
// Each macro expects signals named clk and arst_n in the using scope.
`ifndef ARCSINE_POLYNOMIAL_ASSERT_SVH
`define ARCSINE_POLYNOMIAL_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASP_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("arcsine_polynomial: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("arcsine_polynomial: assertion failed");

`endif

// ----- sv/asp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asp_pkg
// Types and Q30 constants of the arcsine polynomial datapath.
// ----------------------------------------------------------------------------
package asp_pkg;

	localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
	localparam logic [30:0] Q30_HALF = 31'h2000_0000;
	localparam logic [30:0] TINY_Q30 = 31'd107375;
	localparam logic [31:0] COEF4    = 32'd45272390;
	localparam logic [31:0] COEF3    = 32'd25964485;
	localparam logic [31:0] COEF2    = 32'd48823069;
	localparam logic [31:0] COEF1    = 32'd80480174;
	localparam logic [31:0] COEF0    = 32'd178957891;
	localparam logic [31:0] PIO2_Q30 = 32'd1686629713;
	localparam logic [14:0] MAG_MAX  = 15'd32767;

	// square root: one result bit per stage, 60-bit radicand
	localparam int SQ_STEPS = 30;

	typedef logic [59:0] sq_word_t;

	typedef struct packed {
		logic        neg;
		logic        clamp;
		logic        tiny;
		logic        reflect;
		logic [16:0] a;
		logic [30:0] a30;
		logic [30:0] z;
	} meta_t;

	// Q30 product, truncated
	function automatic logic [31:0] mulq30(input logic [31:0] p, input logic [31:0] q);
		logic [63:0] prod;
		prod = {32'd0, p} * {32'd0, q};
		return prod[61:30];
	endfunction

endpackage

// ----- sv/asp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asp_in_if / asp_out_if
// Valid/ready channels of the arcsine polynomial block.
// ----------------------------------------------------------------------------
interface asp_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] x_in;

	modport source (output valid, output x_in, input ready);
	modport sink (input valid, input x_in, output ready);
endinterface

interface asp_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] angle;
	logic               out_of_domain;

	modport source (output valid, output angle, output out_of_domain, input ready);
	modport sink (input valid, input angle, input out_of_domain, output ready);
endinterface

// ----- sv/arcsine_polynomial.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcsine_polynomial
// Pipelined fixed-point arcsine: Q1.FRAC_BITS in, Q1.FRAC_BITS radians out.
// ----------------------------------------------------------------------------
// Takes one sample per cycle unless the output stalls, and computes its arcsine
// in 2 setup stages, 30 square-root stages of one root bit each, 4 Horner
// stages, 2 product stages, reflection and the output register. All stages
// advance together; when the result is not taken the whole pipe holds, so
// sample.ready follows result.ready whenever a result is waiting. Inputs
// beyond +-1 are clamped to +-pi/2 with out_of_domain set; magnitudes below
// 1e-4 pass through unchanged, sign included.

`include "arcsine_polynomial_assert.svh"

module arcsine_polynomial #(
	parameter int FRAC_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	asp_in_if.sink    sample,
	asp_out_if.source result
);
	import asp_pkg::*;

	localparam int SH = 30 - FRAC_BITS;
	localparam logic [30:0] ONE_A = 31'(64'd1 << FRAC_BITS);
	localparam logic [63:0] PIO2_RND = (SH == 0) ? 64'(PIO2_Q30) :
		((64'(PIO2_Q30) + (64'd1 << ((SH == 0) ? 0 : SH - 1))) >> SH);
	localparam logic [14:0] PIO2_MAG = (PIO2_RND > 64'(MAG_MAX)) ? MAG_MAX : 15'(PIO2_RND);

	logic en;
	logic out_vld_q;

	// ---- s1: magnitude and clamp
	logic        vld_s1;
	meta_t       m_s1;
	logic [30:0] a_ext;
	logic [30:0] a_cl;
	logic [30:0] a30_c;
	logic        neg_c;
	logic [16:0] mag_in;

	assign en = !out_vld_q || result.ready;
	assign sample.ready = en;

	assign neg_c  = sample.x_in[15];
	assign mag_in = neg_c ? (17'h10000 - {1'b0, sample.x_in}) : {1'b0, sample.x_in};
	assign a_ext  = {14'd0, mag_in};
	assign a_cl   = (a_ext > ONE_A) ? ONE_A : a_ext;
	assign a30_c  = a_cl << SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1.neg     <= neg_c;
			m_s1.clamp   <= a_ext > ONE_A;
			m_s1.a       <= a_cl[16:0];
			m_s1.a30     <= a30_c;
			m_s1.tiny    <= a30_c < TINY_Q30;
			m_s1.reflect <= a30_c > Q30_HALF;
			m_s1.z       <= '0;
		end
	end

	// ---- s2: z and square-root radicand
	logic [30:0] z31_c;
	logic [61:0] sq_c;
	meta_t       sq_meta_c;
	logic        sq_vld_s [0:SQ_STEPS];
	meta_t       sq_meta_s [0:SQ_STEPS];
	sq_word_t    sq_v_s [0:SQ_STEPS];
	sq_word_t    sq_r_s [0:SQ_STEPS];

	assign z31_c = Q30_ONE - m_s1.a30;
	assign sq_c  = {31'd0, m_s1.a30} * {31'd0, m_s1.a30};

	always_comb begin
		sq_meta_c   = m_s1;
		sq_meta_c.z = m_s1.reflect ? (z31_c >> 1) : sq_c[60:30];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s[0] <= 1'b0;
		end else if (en) begin
			sq_vld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_meta_s[0] <= sq_meta_c;
			sq_v_s[0]    <= {z31_c[30:0], 29'd0};
			sq_r_s[0]    <= '0;
		end
	end

	// ---- square root, one bit per stage
	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
		localparam sq_word_t BIT_W = sq_word_t'(60'd1 << (2 * (SQ_STEPS - 1 - i)));
		sq_word_t trial;
		assign trial = sq_r_s[i] + BIT_W;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[i+1] <= 1'b0;
			end else if (en) begin
				sq_vld_s[i+1] <= sq_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_meta_s[i+1] <= sq_meta_s[i];
				if (sq_v_s[i] >= trial) begin
					sq_v_s[i+1] <= sq_v_s[i] - trial;
					sq_r_s[i+1] <= (sq_r_s[i] >> 1) + BIT_W;
				end else begin
					sq_v_s[i+1] <= sq_v_s[i];
					sq_r_s[i+1] <= sq_r_s[i] >> 1;
				end
			end
		end
	end

	// ---- Horner chain and final products
	meta_t       m_h1, m_h2, m_h3, m_h4, m_m1, m_m2, m_rf;
	logic        vld_h1, vld_h2, vld_h3, vld_h4, vld_m1, vld_m2, vld_rf;
	logic [30:0] s_h1, s_h2, s_h3, s_h4, s_m1;
	logic [31:0] p_h1, p_h2, p_h3, p_h4, t_m1, r_m2, r_rf;
	logic [30:0] root_c;
	logic [31:0] z32_top;
	logic [32:0] twice_c;

	assign root_c  = sq_r_s[SQ_STEPS][30:0];
	assign z32_top = {1'b0, sq_meta_s[SQ_STEPS].z};
	assign twice_c = {r_m2, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_h1 <= 1'b0;
			vld_h2 <= 1'b0;
			vld_h3 <= 1'b0;
			vld_h4 <= 1'b0;
			vld_m1 <= 1'b0;
			vld_m2 <= 1'b0;
			vld_rf <= 1'b0;
		end else if (en) begin
			vld_h1 <= sq_vld_s[SQ_STEPS];
			vld_h2 <= vld_h1;
			vld_h3 <= vld_h2;
			vld_h4 <= vld_h3;
			vld_m1 <= vld_h4;
			vld_m2 <= vld_m1;
			vld_rf <= vld_m2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_h1 <= sq_meta_s[SQ_STEPS];
			s_h1 <= sq_meta_s[SQ_STEPS].reflect ? root_c : sq_meta_s[SQ_STEPS].a30;
			p_h1 <= mulq30(COEF4, z32_top) + COEF3;

			m_h2 <= m_h1;
			s_h2 <= s_h1;
			p_h2 <= mulq30(p_h1, {1'b0, m_h1.z}) + COEF2;

			m_h3 <= m_h2;
			s_h3 <= s_h2;
			p_h3 <= mulq30(p_h2, {1'b0, m_h2.z}) + COEF1;

			m_h4 <= m_h3;
			s_h4 <= s_h3;
			p_h4 <= mulq30(p_h3, {1'b0, m_h3.z}) + COEF0;

			m_m1 <= m_h4;
			s_m1 <= s_h4;
			t_m1 <= mulq30(p_h4, {1'b0, m_h4.z});

			m_m2 <= m_m1;
			r_m2 <= {1'b0, s_m1} + mulq30(t_m1, {1'b0, s_m1});

			// reflect about pi/2, floor at zero
			m_rf <= m_m2;
			if (!m_m2.reflect) begin
				r_rf <= r_m2;
			end else if (twice_c >= {1'b0, PIO2_Q30}) begin
				r_rf <= '0;
			end else begin
				r_rf <= PIO2_Q30 - twice_c[31:0];
			end
		end
	end

	// ---- round, saturate, sign
	logic [32:0] rnd_c;
	logic [32:0] mag_full;
	logic [14:0] mag_c;
	logic [15:0] angle_q;
	logic        ood_q;

	if (SH == 0) begin : g_noround
		assign rnd_c = {1'b0, r_rf};
	end else begin : g_round
		assign rnd_c = ({1'b0, r_rf} + (33'd1 << ((SH == 0) ? 0 : SH - 1))) >> SH;
	end

	assign mag_full = m_rf.tiny ? {16'd0, m_rf.a} : rnd_c;
	assign mag_c    = (mag_full > 33'(MAG_MAX)) ? MAG_MAX : mag_full[14:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_rf;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_q <= m_rf.neg ? (16'd0 - {1'b0, mag_c}) : {1'b0, mag_c};
			ood_q   <= m_rf.clamp;
		end
	end

	assign result.valid         = out_vld_q;
	assign result.angle         = angle_q;
	assign result.out_of_domain = ood_q;

	// ---- checks
	`ASP_ASSERT_IMPL(a_direct_grows, vld_m2 && !m_m2.reflect && !m_m2.tiny, (r_m2 >= {1'b0, m_m2.a30}))
	`ASP_ASSERT_IMPL(a_reflect_bound, vld_rf && m_rf.reflect, r_rf <= PIO2_Q30)
	`ASP_ASSERT_IMPL(a_clamp_pio2, out_vld_q && ood_q, (angle_q == {1'b0, PIO2_MAG}) || (angle_q == (16'd0 - {1'b0, PIO2_MAG})))
	`ASP_ASSERT_NEXT(a_hold_on_stall, out_vld_q && !result.ready, out_vld_q && $stable(angle_q) && $stable(ood_q))

endmodule
